// ----- hw/rtl/grid_diffusion_decay_stencil_unit_defines.svh -----
// Assertion helpers shared by the stencil RTL.
`ifndef GRID_DIFFUSION_DECAY_STENCIL_UNIT_DEFINES_SVH
`define GRID_DIFFUSION_DECAY_STENCIL_UNIT_DEFINES_SVH

// same-cycle implication
`define GDDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GDDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gdds_pkg.sv -----
package gdds_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int VALUE_W  = 16;
  localparam int SIZE_W   = 7;
  localparam int RATE_W   = 16;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);

  // register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd3;

  // neighbor slots
  localparam int NB_NUM = 4;
  localparam int NB_UP  = 0;
  localparam int NB_DN  = 1;
  localparam int NB_LF  = 2;
  localparam int NB_RT  = 3;

  // result kinds per request, in output order
  localparam int KIND_NUM    = 3;
  localparam int KIND_MID    = 0;
  localparam int KIND_LEFT   = 1;
  localparam int KIND_CORNER = 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_of_run;
    logic             end_of_frame;
  } gdds_tag_t;

  typedef struct packed {
    logic [VALUE_W-1:0]             p;
    logic [NB_NUM-1:0][VALUE_W-1:0] nb;
    logic [NB_NUM-1:0]              nb_en;
    gdds_tag_t                      tag;
  } gdds_operands_t;

  typedef struct packed {
    logic [VALUE_W-1:0] new_value;
    gdds_tag_t          tag;
  } gdds_result_t;

endpackage

// ----- hw/rtl/gdds_stencil_front.sv -----
`include "grid_diffusion_decay_stencil_unit_defines.svh"

module gdds_stencil_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gdds_pkg::VALUE_W-1:0]  in_cell_value,
  input  logic [gdds_pkg::SIZE_W-1:0]   rows_i,
  input  logic [gdds_pkg::SIZE_W-1:0]   cols_i,
  input  logic                          issue_ok,
  output logic                          op_valid,
  output gdds_pkg::gdds_operands_t      op
);

  localparam int W = gdds_pkg::VALUE_W;

  typedef struct packed {
    logic [W-1:0]                   v;
    logic [W-1:0]                   w0;
    logic [W-1:0]                   w1;
    logic [gdds_pkg::ROW_W-1:0]     row;
    logic [gdds_pkg::COL_W-1:0]     col;
    logic                           has_up;
    logic                           has_left;
    logic                           has_right;
    logic                           col_gt1;
  } front_item_t;

  // position of the next request
  logic [gdds_pkg::ROW_W-1:0] row_r, row_nxt, cur_row;
  logic [gdds_pkg::COL_W-1:0] col_r, col_nxt, cur_col;
  logic [gdds_pkg::SIZE_W-1:0] col_inc, row_inc;
  logic restart, in_fire;

  logic [W-1:0] last_r, prior_r;

  // line memory entry: {upper, middle}
  logic [2*W-1:0] line_mem [gdds_pkg::MAX_COLS];
  logic [2*W-1:0] rd0_r, rd1_r, rd0, rd1, fwd_data_r, mem_wdata;
  logic           fwd0_r, fwd1_r, mem_we;
  logic [gdds_pkg::COL_W-1:0] ra0, ra1;

  front_item_t                      s1_r, s1_nxt;
  logic [gdds_pkg::KIND_NUM-1:0]    s1_mask_r, s1_mask_nxt;
  logic                             s1_valid_r, s1_adv;

  front_item_t                      s2_r;
  logic [W-1:0]                     s2_up_r, s2_mid_r, s2_right_r, s2_left_r, prev_mid_r;
  logic [gdds_pkg::KIND_NUM-1:0]    s2_mask_r, pick, rest;
  logic                             s2_valid_r, s2_done, s2_free;

  assign restart = (gdds_pkg::SIZE_W'(row_r) >= rows_i) || (gdds_pkg::SIZE_W'(col_r) >= cols_i);
  assign cur_row = restart ? '0 : row_r;
  assign cur_col = restart ? '0 : col_r;
  assign col_inc = gdds_pkg::SIZE_W'(cur_col) + gdds_pkg::SIZE_W'(1);
  assign row_inc = gdds_pkg::SIZE_W'(cur_row) + gdds_pkg::SIZE_W'(1);

  assign in_fire = in_valid && in_ready;
  assign s2_free = !s2_valid_r || s2_done;
  assign s1_adv  = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;

  always_comb begin
    if (col_inc >= cols_i) begin
      col_nxt = '0;
      row_nxt = (row_inc >= rows_i) ? '0 : row_inc[gdds_pkg::ROW_W-1:0];
    end else begin
      col_nxt = col_inc[gdds_pkg::COL_W-1:0];
      row_nxt = cur_row;
    end
  end

  assign ra0 = cur_col;
  assign ra1 = col_inc[gdds_pkg::COL_W-1:0];

  always_comb begin
    s1_nxt.v         = in_cell_value;
    s1_nxt.w0        = prior_r;
    s1_nxt.w1        = last_r;
    s1_nxt.row       = cur_row;
    s1_nxt.col       = cur_col;
    s1_nxt.has_up    = cur_row > gdds_pkg::ROW_W'(1);
    s1_nxt.has_left  = cur_col != '0;
    s1_nxt.has_right = col_inc < cols_i;
    s1_nxt.col_gt1   = cur_col > gdds_pkg::COL_W'(1);
    s1_mask_nxt = '0;
    s1_mask_nxt[gdds_pkg::KIND_MID]    = cur_row != '0;
    s1_mask_nxt[gdds_pkg::KIND_LEFT]   = (row_inc == rows_i) && (cur_col != '0);
    s1_mask_nxt[gdds_pkg::KIND_CORNER] = (row_inc == rows_i) && (col_inc == cols_i);
  end

  // read data, with bypass of the write that lands on the same edge as the read
  assign rd0 = fwd0_r ? fwd_data_r : rd0_r;
  assign rd1 = fwd1_r ? fwd_data_r : rd1_r;

  assign mem_we    = s1_adv;
  assign mem_wdata = {rd0[W-1:0], s1_r.v};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_r.col] <= mem_wdata;
    end
    if (in_fire) begin
      rd0_r      <= line_mem[ra0];
      rd1_r      <= line_mem[ra1];
      fwd0_r     <= mem_we && (s1_r.col == ra0);
      fwd1_r     <= mem_we && (s1_r.col == ra1);
      fwd_data_r <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      last_r     <= '0;
      prior_r    <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s1_mask_r  <= '0;
      s2_mask_r  <= '0;
    end else begin
      if (in_fire) begin
        row_r   <= row_nxt;
        col_r   <= col_nxt;
        prior_r <= last_r;
        last_r  <= in_cell_value;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        s1_mask_r  <= s1_mask_nxt;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
        s2_mask_r  <= s1_mask_r;
      end else if (s2_done) begin
        s2_valid_r <= 1'b0;
        s2_mask_r  <= '0;
      end else if (op_valid) begin
        s2_mask_r  <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      s2_r       <= s1_r;
      s2_up_r    <= rd0[2*W-1:W];
      s2_mid_r   <= rd0[W-1:0];
      s2_right_r <= rd1[W-1:0];
      s2_left_r  <= prev_mid_r;
      prev_mid_r <= rd0[W-1:0];
    end
  end

  // lowest pending kind goes first
  assign pick = s2_mask_r & (~s2_mask_r + gdds_pkg::KIND_NUM'(1));
  assign rest = s2_mask_r & ~pick;

  assign op_valid = s2_valid_r && (s2_mask_r != '0) && issue_ok;
  assign s2_done  = s2_valid_r && ((s2_mask_r == '0) || (issue_ok && (rest == '0)));

  always_comb begin
    op = '0;
    op.tag.row         = s2_r.row;
    op.tag.col         = s2_r.col;
    op.tag.last_of_run = rest == '0;
    if (pick[gdds_pkg::KIND_MID]) begin
      // cell one row up: left is the previous column of that row
      op.p                       = s2_mid_r;
      op.nb[gdds_pkg::NB_UP]     = s2_up_r;
      op.nb_en[gdds_pkg::NB_UP]  = s2_r.has_up;
      op.nb[gdds_pkg::NB_DN]     = s2_r.v;
      op.nb_en[gdds_pkg::NB_DN]  = 1'b1;
      op.nb[gdds_pkg::NB_LF]     = s2_left_r;
      op.nb_en[gdds_pkg::NB_LF]  = s2_r.has_left;
      op.nb[gdds_pkg::NB_RT]     = s2_right_r;
      op.nb_en[gdds_pkg::NB_RT]  = s2_r.has_right;
      op.tag.row                 = s2_r.row - gdds_pkg::ROW_W'(1);
    end else if (pick[gdds_pkg::KIND_LEFT]) begin
      op.p                       = s2_r.w1;
      op.nb[gdds_pkg::NB_UP]     = s2_left_r;
      op.nb_en[gdds_pkg::NB_UP]  = 1'b1;
      op.nb[gdds_pkg::NB_LF]     = s2_r.w0;
      op.nb_en[gdds_pkg::NB_LF]  = s2_r.col_gt1;
      op.nb[gdds_pkg::NB_RT]     = s2_r.v;
      op.nb_en[gdds_pkg::NB_RT]  = 1'b1;
      op.tag.col                 = s2_r.col - gdds_pkg::COL_W'(1);
    end else begin
      // bottom-right corner of the frame
      op.p                       = s2_r.v;
      op.nb[gdds_pkg::NB_UP]     = s2_mid_r;
      op.nb_en[gdds_pkg::NB_UP]  = 1'b1;
      op.nb[gdds_pkg::NB_LF]     = s2_r.w1;
      op.nb_en[gdds_pkg::NB_LF]  = 1'b1;
      op.tag.end_of_frame        = 1'b1;
    end
  end

  `GDDS_ASSERT_NEXT(a_pos_in_frame, in_fire, (gdds_pkg::SIZE_W'(row_r) < $past(rows_i)) && (gdds_pkg::SIZE_W'(col_r) < $past(cols_i)), "position left the frame")
  `GDDS_ASSERT_NOW(a_eof_is_last, op_valid && op.tag.end_of_frame, op.tag.last_of_run, "end of frame before last result of run")
  `GDDS_ASSERT_NEXT(a_s2_holds, s2_valid_r && !s2_done, s2_valid_r && $stable(s2_r), "issue stage dropped its request")

endmodule

// ----- hw/rtl/gdds_cell_update.sv -----
module gdds_cell_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          op_valid,
  input  gdds_pkg::gdds_operands_t      op,
  input  logic [gdds_pkg::RATE_W-1:0]   diffuse_i,
  input  logic [gdds_pkg::RATE_W-1:0]   decay_i,
  output logic                          res_valid,
  output gdds_pkg::gdds_result_t        res
);

  localparam int W          = gdds_pkg::VALUE_W;
  localparam int LAP_W      = W + 3;
  localparam int PROD_W     = gdds_pkg::RATE_W + 1 + LAP_W;
  localparam int DIFF_SHIFT = gdds_pkg::RATE_W + 2;   // Q0.16 rate, quartered
  localparam int DIFF_W     = PROD_W - DIFF_SHIFT;
  localparam int DEC_W      = gdds_pkg::RATE_W + W;
  localparam int RES_W      = DIFF_W + 1;

  logic signed [LAP_W-1:0]  lap;
  logic signed [PROD_W-1:0] diff_prod;
  logic [DEC_W-1:0]         dec_prod;

  logic                     s3_valid_r;
  logic [W-1:0]             s3_p_r;
  logic [W-1:0]             s3_dec_r;
  logic [DIFF_W-1:0]        s3_diff_r;
  gdds_pkg::gdds_tag_t      s3_tag_r;
  logic signed [RES_W-1:0]  sum;

  always_comb begin
    lap = '0;
    for (int i = 0; i < gdds_pkg::NB_NUM; i++) begin
      if (op.nb_en[i]) begin
        lap = lap + (LAP_W'(op.nb[i]) - LAP_W'(op.p));
      end
    end
  end

  assign diff_prod = PROD_W'($signed({1'b0, diffuse_i})) * PROD_W'(lap);
  assign dec_prod  = DEC_W'(decay_i) * DEC_W'(op.p);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= op_valid;
    end
  end

  // arithmetic shift of the signed product floors toward minus infinity
  always_ff @(posedge clk) begin
    if (op_valid) begin
      s3_p_r    <= op.p;
      s3_dec_r  <= dec_prod[DEC_W-1 -: W];
      s3_diff_r <= diff_prod[DIFF_SHIFT +: DIFF_W];
      s3_tag_r  <= op.tag;
    end
  end

  assign sum = $signed(RES_W'(s3_p_r)) - $signed(RES_W'(s3_dec_r))
             + $signed({s3_diff_r[DIFF_W-1], s3_diff_r});

  always_comb begin
    res.tag = s3_tag_r;
    if (sum[RES_W-1]) begin
      res.new_value = '0;
    end else if (sum[RES_W-2:W] != '0) begin
      res.new_value = '1;
    end else begin
      res.new_value = sum[W-1:0];
    end
  end

  assign res_valid = s3_valid_r;

endmodule

// ----- hw/rtl/gdds_result_fifo.sv -----
module gdds_result_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push_i,
  input  gdds_pkg::gdds_result_t            push_data_i,
  input  logic                              pop_i,
  output logic                              out_valid_o,
  output gdds_pkg::gdds_result_t            out_data_o,
  output logic [gdds_pkg::FIFO_CNT_W-1:0]   count_o
);

  gdds_pkg::gdds_result_t             slots [gdds_pkg::FIFO_DEPTH];
  logic [gdds_pkg::FIFO_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [gdds_pkg::FIFO_CNT_W-1:0]    count_r;
  logic                               pop;

  assign out_valid_o = count_r != '0;
  assign out_data_o  = slots[rd_ptr_r];
  assign count_o     = count_r;
  assign pop         = pop_i && out_valid_o;

  always_ff @(posedge clk) begin
    if (push_i) begin
      slots[wr_ptr_r] <= push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + gdds_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + gdds_pkg::FIFO_PTR_W'(1);
      end
      case ({push_i, pop})
        2'b10:   count_r <= count_r + gdds_pkg::FIFO_CNT_W'(1);
        2'b01:   count_r <= count_r - gdds_pkg::FIFO_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hw/rtl/grid_diffusion_decay_stencil_unit.sv -----
// Streaming five-point diffusion/decay step over a grid of up to 64x64 cells.
// Input channel (in_*): one old cell value per request, raster order. The block
// tracks row/column itself; results lag the input by one grid row.
// Result channel (out_*): new value plus its row/column. A request on row 0
// gives nothing; on row r it gives cell (r-1, c); on the last row it also gives
// (r, c-1) and, at the last column, (r, c) flagged end_of_frame. last_of_run
// marks the final result of each request.
// Config port (cfg_*): single-cycle writes of rows, cols, diffusion and decay
// rates; write only while the block is idle. Sizes are clamped to 2..64.
// Each result passes the input stage, issue stage, update register and queue.
// Throughput: one request per cycle while the issue stage is free; it issues one
// result per cycle through a single shared update unit while the queue has room,
// so last-row requests past column 0 need two results (three for the final cell).
// Reset: position returns to (0,0), sizes to 64, rates to 0; the line memory
// is not cleared and is valid once the first row has been streamed.
// Receiver stall: a 4-entry result queue absorbs it; when it fills the issue
// stage holds and in_ready drops after the one-request input stage is full.
`include "grid_diffusion_decay_stencil_unit_defines.svh"

module grid_diffusion_decay_stencil_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gdds_pkg::VALUE_W-1:0]      in_cell_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gdds_pkg::VALUE_W-1:0]      out_new_value,
  output logic [gdds_pkg::ROW_W-1:0]        out_row,
  output logic [gdds_pkg::COL_W-1:0]        out_col,
  output logic                              out_last_of_run,
  output logic                              out_end_of_frame,
  input  logic                              cfg_we,
  input  logic [gdds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdds_pkg::RATE_W-1:0]       cfg_data
);

  logic [gdds_pkg::SIZE_W-1:0]   rows_r, cols_r, rows_nxt, cols_nxt, size_in;
  logic [gdds_pkg::RATE_W-1:0]   diffuse_r, decay_r;

  logic                          issue_ok, op_valid, res_valid;
  gdds_pkg::gdds_operands_t      op;
  gdds_pkg::gdds_result_t        res, head;
  logic [gdds_pkg::FIFO_CNT_W-1:0] fifo_count, fill;

  assign size_in = cfg_data[gdds_pkg::SIZE_W-1:0];

  always_comb begin
    if (size_in < gdds_pkg::SIZE_W'(2)) begin
      rows_nxt = gdds_pkg::SIZE_W'(2);
    end else if (size_in > gdds_pkg::SIZE_W'(gdds_pkg::MAX_ROWS)) begin
      rows_nxt = gdds_pkg::SIZE_W'(gdds_pkg::MAX_ROWS);
    end else begin
      rows_nxt = size_in;
    end
    if (size_in < gdds_pkg::SIZE_W'(2)) begin
      cols_nxt = gdds_pkg::SIZE_W'(2);
    end else if (size_in > gdds_pkg::SIZE_W'(gdds_pkg::MAX_COLS)) begin
      cols_nxt = gdds_pkg::SIZE_W'(gdds_pkg::MAX_COLS);
    end else begin
      cols_nxt = size_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= gdds_pkg::SIZE_W'(gdds_pkg::MAX_ROWS);
      cols_r    <= gdds_pkg::SIZE_W'(gdds_pkg::MAX_COLS);
      diffuse_r <= '0;
      decay_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gdds_pkg::REG_ROWS:    rows_r    <= rows_nxt;
        gdds_pkg::REG_COLS:    cols_r    <= cols_nxt;
        gdds_pkg::REG_DIFFUSE: diffuse_r <= cfg_data;
        gdds_pkg::REG_DECAY:   decay_r   <= cfg_data;
        default:               rows_r    <= rows_r;
      endcase
    end
  end

  // credit: queue entries plus the result in the update register
  assign fill     = fifo_count + gdds_pkg::FIFO_CNT_W'(res_valid);
  assign issue_ok = fill < gdds_pkg::FIFO_CNT_W'(gdds_pkg::FIFO_DEPTH);

  gdds_stencil_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cell_value (in_cell_value),
    .rows_i        (rows_r),
    .cols_i        (cols_r),
    .issue_ok      (issue_ok),
    .op_valid      (op_valid),
    .op            (op)
  );

  gdds_cell_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op        (op),
    .diffuse_i (diffuse_r),
    .decay_i   (decay_r),
    .res_valid (res_valid),
    .res       (res)
  );

  gdds_result_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (out_ready),
    .out_valid_o (out_valid),
    .out_data_o  (head),
    .count_o     (fifo_count)
  );

  assign out_new_value    = head.new_value;
  assign out_row          = head.tag.row;
  assign out_col          = head.tag.col;
  assign out_last_of_run  = head.tag.last_of_run;
  assign out_end_of_frame = head.tag.end_of_frame;

  `GDDS_ASSERT_NOW(a_fifo_no_overflow, res_valid, fifo_count < gdds_pkg::FIFO_CNT_W'(gdds_pkg::FIFO_DEPTH), "result queue overflow")

endmodule

// ----- verif/grid_diffusion_decay_stencil_unit_test.sv -----
module grid_diffusion_decay_stencil_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gdds_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int TARGET_CELLS   = 470;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               last_run;
    logic               frame_end;
  } cell_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [VALUE_W-1:0]   in_cell_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VALUE_W-1:0]   out_new_value;
  logic [ROW_W-1:0]     out_row;
  logic [COL_W-1:0]     out_col;
  logic                 out_last_of_run;
  logic                 out_end_of_frame;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS;
  logic [RATE_W-1:0]    cfg_data = '0;

  grid_diffusion_decay_stencil_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cell_value    (in_cell_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_value    (out_new_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the block's registers and stream state
  logic [SIZE_W-1:0]  rows_cfg = 7'd64;
  logic [SIZE_W-1:0]  cols_cfg = 7'd64;
  logic [RATE_W-1:0]  diffuse_cfg = '0;
  logic [RATE_W-1:0]  decay_cfg = '0;
  logic [VALUE_W-1:0] upper_row [MAX_COLS];
  logic [VALUE_W-1:0] middle_row [MAX_COLS];
  logic [VALUE_W-1:0] window_q [3] = '{'0, '0, '0};
  int                 row_pos = 0;
  int                 col_pos = 0;

  cell_result_t       expected_cells [$];
  logic [VALUE_W-1:0] cell_queue [$];

  int cells_planned  = 0;
  int cells_accepted = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int setups_done    = 0;
  int idle_style     = 0;  // bit 0: sender gaps, bit 1: receiver stalls
  int burst_left     = 1;
  int gap_left       = 0;
  int ready_hold     = 0;
  int idle_cycles    = 0;

  function automatic int clamp_size(logic [SIZE_W-1:0] v, int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [VALUE_W-1:0] diffuse_cell(
      logic [VALUE_W-1:0] p,
      bit hu, logic [VALUE_W-1:0] up, bit hd, logic [VALUE_W-1:0] dn,
      bit hl, logic [VALUE_W-1:0] lf, bit hr, logic [VALUE_W-1:0] rt);
    longint pv;
    longint lap;
    longint loss;
    longint res;
    pv  = longint'(p);
    lap = 0;
    if (hu) lap += longint'(up) - pv;
    if (hd) lap += longint'(dn) - pv;
    if (hl) lap += longint'(lf) - pv;
    if (hr) lap += longint'(rt) - pv;
    loss = (longint'(decay_cfg) * pv) >>> 16;
    // arithmetic shift floors toward minus infinity
    res = pv - loss + ((longint'(diffuse_cfg) * lap) >>> 18);
    if (res < 0) return '0;
    if (res > longint'({VALUE_W{1'b1}})) return '1;
    return res[VALUE_W-1:0];
  endfunction

  function automatic void advance_diffusion(logic [VALUE_W-1:0] v);
    int           rows;
    int           cols;
    int           r;
    int           c;
    bit           hl;
    bit           hr;
    cell_result_t found [$];
    cell_result_t res_item;
    rows = clamp_size(rows_cfg, MAX_ROWS);
    cols = clamp_size(cols_cfg, MAX_COLS);
    if (row_pos >= rows || col_pos >= cols) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    window_q[0] = window_q[1];
    window_q[1] = window_q[2];
    window_q[2] = v;

    if (r >= 1) begin
      hl = c > 0;
      hr = c + 1 < cols;
      res_item.value = diffuse_cell(middle_row[c], r > 1, upper_row[c], 1'b1, v,
                                    hl, hl ? upper_row[c-1] : '0,
                                    hr, hr ? middle_row[c+1] : '0);
      res_item.row       = ROW_W'(r - 1);
      res_item.col       = COL_W'(c);
      res_item.last_run  = 1'b0;
      res_item.frame_end = 1'b0;
      found.push_back(res_item);
    end

    upper_row[c]  = middle_row[c];
    middle_row[c] = v;

    if (r == rows - 1) begin
      if (c >= 1) begin
        hl = c > 1;
        res_item.value = diffuse_cell(window_q[1], 1'b1, upper_row[c-1], 1'b0, '0,
                                      hl, window_q[0], 1'b1, window_q[2]);
        res_item.row       = ROW_W'(r);
        res_item.col       = COL_W'(c - 1);
        res_item.last_run  = 1'b0;
        res_item.frame_end = 1'b0;
        found.push_back(res_item);
      end
      if (c == cols - 1) begin
        res_item.value = diffuse_cell(window_q[2], 1'b1, upper_row[c], 1'b0, '0,
                                      1'b1, window_q[1], 1'b0, '0);
        res_item.row       = ROW_W'(r);
        res_item.col       = COL_W'(c);
        res_item.last_run  = 1'b0;
        res_item.frame_end = 1'b1;
        found.push_back(res_item);
      end
    end

    if (found.size() > 0) found[found.size()-1].last_run = 1'b1;
    foreach (found[i]) expected_cells.push_back(found[i]);

    col_pos = c + 1;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= rows) row_pos = 0;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want,
                                 cell_result_t item);
    $display("[%0t] mismatch %s: got %0h, expected %0h (cell %0d,%0d)",
             $realtime, what, got, want, item.row, item.col);
    mismatches++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ROWS:    rows_cfg    = data[SIZE_W-1:0];
      REG_COLS:    cols_cfg    = data[SIZE_W-1:0];
      REG_DIFFUSE: diffuse_cfg = data;
      REG_DECAY:   decay_cfg   = data;
      default: ;
    endcase
  endtask

  task automatic program_setup(int rows_w, int cols_w, int diffuse, int decay);
    write_reg(REG_ROWS, rows_w[RATE_W-1:0]);
    write_reg(REG_COLS, cols_w[RATE_W-1:0]);
    write_reg(REG_DIFFUSE, diffuse[RATE_W-1:0]);
    write_reg(REG_DECAY, decay[RATE_W-1:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    setups_done++;
  endtask

  // every request accepted, every result back, then let the pipe settle
  task automatic wait_quiet();
    while (cells_accepted != cells_planned || expected_cells.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_cell(logic [VALUE_W-1:0] v);
    cell_queue.push_back(v);
    cells_planned++;
  endtask

  // mode 0: uniform, 1: mostly rails, 2: smooth field around a random level
  task automatic queue_random(int n, int mode);
    int level;
    int v;
    level = $urandom_range(0, 65535);
    for (int i = 0; i < n; i++) begin
      case (mode)
        1: v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
               ($urandom_range(0, 1) ? 65535 : 0);
        2: begin
          v = level + $urandom_range(0, 512) - 256;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
        end
        default: v = $urandom_range(0, 65535);
      endcase
      queue_cell(v[VALUE_W-1:0]);
    end
  endtask

  function automatic int pick_size();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return $urandom_range(0, 1);
    return $urandom_range(2, 9);
  endfunction

  function automatic int pick_rate();
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return 0;
    if (k == 1) return 65535;
    return $urandom_range(0, 65535);
  endfunction

  // sender: bursts, with random gaps when bit 0 of idle_style is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_diffusion(in_cell_value);
        cells_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cell_queue.size() > 0) begin
          in_valid      <= 1'b1;
          in_cell_value <= cell_queue.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            if (idle_style[0])
              gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) :
                         $urandom_range(0, 5);
            else
              gap_left = 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: always ready, or with bit 1 of idle_style alternating ready and stall runs, sometimes long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!idle_style[1]) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) :
                   $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
      ready_hold = $urandom_range(0, 12);
    end
  end

  cell_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_cells.size() == 0) begin
        want.row = out_row;
        want.col = out_col;
        report_mismatch("result with nothing pending", out_new_value, 0, want);
      end else begin
        want = expected_cells.pop_front();
        if (out_new_value !== want.value)
          report_mismatch("new_value", out_new_value, want.value, want);
        if (out_row !== want.row)
          report_mismatch("row", out_row, want.row, want);
        if (out_col !== want.col)
          report_mismatch("col", out_col, want.col, want);
        if (out_last_of_run !== want.last_run)
          report_mismatch("last_of_run", out_last_of_run, want.last_run, want);
        if (out_end_of_frame !== want.frame_end)
          report_mismatch("end_of_frame", out_end_of_frame, want.frame_end, want);
      end
    end
  end

  // watchdog: too long without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no progress, %0d results still pending",
                 $realtime, expected_cells.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int rows_w;
    int cols_w;
    int frames;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // sizes below range clamp to 2x2; full rates drive a corner to zero
    program_setup(0, 1, 65535, 65535);
    queue_cell(16'hFFFF);
    queue_cell(16'h0000);
    queue_cell(16'h0000);
    queue_cell(16'hFFFF);
    wait_quiet();

    // 3x3 checkerboard: interior cell sees all four neighbors
    idle_style = 3;
    program_setup(3, 3, 65535, 0);
    for (int i = 0; i < 9; i++) queue_cell((i % 2) ? 16'h0000 : 16'hFFFF);
    wait_quiet();

    // stop mid-frame, then shrink so the position falls outside: restart at 0,0
    program_setup(3, 4, 16'h4000, 16'h0100);
    queue_random(6, 0);
    wait_quiet();
    program_setup(2, 2, 16'h8000, 16'h8000);
    queue_random(4, 1);
    wait_quiet();

    // largest sizes, one dimension at a time, written above range
    idle_style = $urandom_range(0, 3);
    program_setup(127, 2, pick_rate(), pick_rate());
    queue_random(MAX_ROWS * 2, 0);
    wait_quiet();
    idle_style = $urandom_range(0, 3);
    program_setup(2, 100, pick_rate(), pick_rate());
    queue_random(MAX_COLS * 2, 2);
    wait_quiet();

    while (cells_planned < TARGET_CELLS) begin
      rows_w = pick_size();
      cols_w = pick_size();
      frames = $urandom_range(1, 3);
      idle_style = (setups_done % 4 == 0) ? 0 : $urandom_range(0, 3);
      program_setup(rows_w, cols_w, pick_rate(), pick_rate());
      queue_random(clamp_size(SIZE_W'(rows_w), MAX_ROWS) *
                   clamp_size(SIZE_W'(cols_w), MAX_COLS) * frames,
                   $urandom_range(0, 2));
      wait_quiet();
    end

    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d cells over %0d register setups, %0d results checked.",
             cells_accepted, setups_done, results_seen);
    $display("Frames from 2x2 up to 64 rows or 64 columns, clamped sizes, restart, rate extremes.");
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
